>>> rtl/core/pdf_xref_table_parser_core_assert.svh
// Assertion shorthands shared by the parser RTL.
// Both expect signals named clk and rst_n in the calling module.
`ifndef PDF_XREF_TABLE_PARSER_CORE_ASSERT_SVH
`define PDF_XREF_TABLE_PARSER_CORE_ASSERT_SVH

// Same-cycle implication.
`define PXREF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pxref assertion failed");

// Next-cycle implication.
`define PXREF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pxref assertion failed");

`endif

>>> rtl/core/pxref_pkg.sv
`default_nettype none

package pxref_pkg;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       end_of_data;
    logic       new_table;
  } pxref_in_t;

  typedef struct packed {
    logic [3:0]  result_kind;
    logic [31:0] object_number;
    logic [15:0] generation;
    logic [33:0] byte_offset;
    logic        in_use;
  } pxref_out_t;

  typedef enum logic [3:0] {
    KIND_ENTRY          = 4'd0,
    KIND_TABLE_END      = 4'd1,
    KIND_EOF_KEYWORD    = 4'd2,
    KIND_NO_KEYWORD     = 4'd3,
    KIND_EOF_HEADER     = 4'd4,
    KIND_NO_SPACE       = 4'd5,
    KIND_BAD_RANGE      = 4'd6,
    KIND_EOF_ENTRIES    = 4'd7,
    KIND_SHORT          = 4'd8,
    KIND_BAD_OFFSET     = 4'd9,
    KIND_BAD_GENERATION = 4'd10,
    KIND_BAD_FLAG       = 4'd11
  } pxref_kind_t;

  localparam logic [7:0] CH_NL    = 8'h0a;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_IN_USE = "n";
  localparam logic [7:0] CH_FREE  = "f";

  localparam logic [2:0] XREF_LEN    = 3'd4;
  localparam logic [2:0] TRAILER_LEN = 3'd7;

  // entry line layout, in trimmed columns
  localparam logic [4:0] ENTRY_LEN  = 5'd18;
  localparam logic [4:0] OFF_COLS   = 5'd10;
  localparam logic [4:0] GEN_FIRST  = 5'd11;
  localparam logic [4:0] GEN_END    = 5'd16;
  localparam logic [4:0] FLAG_COL   = 5'd17;
  localparam logic [4:0] COL_MAX    = 5'd31;

  function automatic logic is_blank(input logic [7:0] c);
    return c inside {8'h20, 8'h09, 8'h0a, 8'h0b, 8'h0c, 8'h0d};
  endfunction

  function automatic logic is_token_end(input logic [7:0] c);
    return is_blank(c) || (c inside {"(", ")", "<", ">", "[", "]", "{", "}", "/", "%"});
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {["0":"9"]};
  endfunction

  function automatic logic [7:0] xref_char(input logic [1:0] idx);
    logic [7:0] ch;
    case (idx)
      2'd0:    ch = "x";
      2'd1:    ch = "r";
      2'd2:    ch = "e";
      default: ch = "f";
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] trailer_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = "t";
      3'd1:    ch = "r";
      3'd2:    ch = "a";
      3'd3:    ch = "i";
      3'd4:    ch = "l";
      3'd5:    ch = "e";
      3'd6:    ch = "r";
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/pxref_stream_if.sv
`default_nettype none

interface pxref_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/pxref_parse.sv
`default_nettype none
`include "pdf_xref_table_parser_core_assert.svh"

module pxref_parse import pxref_pkg::*; #(
  parameter int OBJECT_NUMBER_WIDTH = 32
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step_en,
  input  wire pxref_in_t  item,
  output logic            res_valid,
  output pxref_out_t      res
);

  localparam int W  = OBJECT_NUMBER_WIDTH;
  localparam int PW = W + 5;
  localparam logic [W:0] ACC_SAT = {1'b1, {W{1'b0}}};

  typedef enum logic [6:0] {
    PH_KW_LEAD  = 7'b0000001,
    PH_KW_MATCH = 7'b0000010,
    PH_KW_REST  = 7'b0000100,
    PH_SEEK     = 7'b0001000,
    PH_HDR_TRL  = 7'b0010000,
    PH_HDR      = 7'b0100000,
    PH_ENTRY    = 7'b1000000
  } pxref_phase_t;

  // facts about the blank run pending inside a header line
  typedef struct packed {
    logic space;
    logic pre;
    logic post;
  } pxref_run_t;

  typedef struct packed {
    logic split;
    logic s_dig;
    logic s_bad;
    logic c_dig;
    logic c_bad;
  } pxref_hdr_flags_t;

  typedef struct packed {
    logic off_stop;
    logic off_ok;
    logic gen_stop;
    logic gen_ok;
  } pxref_fld_flags_t;

  pxref_phase_t     phase_r, phase_nxt;
  logic [4:0]       col_r, col_nxt;
  logic [4:0]       trim_r, trim_nxt;
  logic [2:0]       tok_idx_r, tok_idx_nxt;
  pxref_run_t       run_r, run_nxt;
  logic             kw_ok_r, kw_ok_nxt;
  logic [W:0]       start_r, start_nxt;
  logic [W:0]       count_r, count_nxt;
  pxref_hdr_flags_t hdr_r, hdr_nxt;
  logic [33:0]      off_r, off_nxt;
  logic [16:0]      gen_r, gen_nxt;
  pxref_fld_flags_t fld_r, fld_nxt;
  logic [7:0]       flag_r, flag_nxt;
  logic [W-1:0]     remain_r, remain_nxt;
  logic [W-1:0]     next_obj_r, next_obj_nxt;
  logic             stopped_r, stopped_nxt;

  logic [7:0]   c;
  logic         nl;
  logic         blank;
  logic         tok_end;
  logic         dig;
  logic [3:0]   digit;
  logic         done;
  logic         do_fail;
  pxref_kind_t  fail_kind;
  logic         clr_line;
  logic [W:0]   acc;
  logic [PW-1:0] acc_prod;
  logic [4:0]   gap_end;

  assign c       = item.byte_value;
  assign nl      = (c == CH_NL);
  assign blank   = is_blank(c);
  assign tok_end = is_token_end(c);
  assign dig     = is_digit(c);
  assign digit   = c[3:0];

  always_comb begin
    phase_nxt    = phase_r;
    col_nxt      = col_r;
    trim_nxt     = trim_r;
    tok_idx_nxt  = tok_idx_r;
    run_nxt      = run_r;
    kw_ok_nxt    = kw_ok_r;
    start_nxt    = start_r;
    count_nxt    = count_r;
    hdr_nxt      = hdr_r;
    off_nxt      = off_r;
    gen_nxt      = gen_r;
    fld_nxt      = fld_r;
    flag_nxt     = flag_r;
    remain_nxt   = remain_r;
    next_obj_nxt = next_obj_r;
    stopped_nxt  = stopped_r;
    res_valid    = 1'b0;
    res          = '0;
    done         = 1'b0;
    do_fail      = 1'b0;
    fail_kind    = KIND_ENTRY;
    clr_line     = 1'b0;
    acc          = '0;
    acc_prod     = '0;
    gap_end      = '0;

    if (step_en) begin
      if (item.new_table) begin
        phase_nxt    = PH_KW_LEAD;
        col_nxt      = '0;
        trim_nxt     = '0;
        tok_idx_nxt  = '0;
        run_nxt      = '0;
        kw_ok_nxt    = 1'b0;
        start_nxt    = '0;
        count_nxt    = '0;
        hdr_nxt      = '0;
        off_nxt      = '0;
        gen_nxt      = '0;
        fld_nxt      = '0;
        flag_nxt     = '0;
        remain_nxt   = '0;
        next_obj_nxt = '0;
        stopped_nxt  = 1'b0;
      end

      if (stopped_nxt) begin
        done = 1'b1;
      end else if (item.end_of_data) begin
        done    = 1'b1;
        do_fail = 1'b1;
        if (phase_nxt inside {PH_KW_LEAD, PH_KW_MATCH, PH_KW_REST}) begin
          fail_kind = KIND_EOF_KEYWORD;
        end else if (phase_nxt == PH_SEEK) begin
          fail_kind = KIND_TABLE_END;
        end else if (phase_nxt == PH_HDR_TRL && tok_idx_nxt == TRAILER_LEN) begin
          fail_kind = KIND_TABLE_END;
        end else if (phase_nxt == PH_ENTRY) begin
          fail_kind = KIND_EOF_ENTRIES;
        end else begin
          fail_kind = KIND_EOF_HEADER;
        end
      end

      // keyword line: leading blanks, then "xref" and a token delimiter
      if (!done && phase_nxt == PH_KW_LEAD) begin
        if (nl) begin
          done      = 1'b1;
          do_fail   = 1'b1;
          fail_kind = KIND_NO_KEYWORD;
        end else if (blank) begin
          done = 1'b1;
        end else begin
          phase_nxt = PH_KW_MATCH;
        end
      end

      if (!done && phase_nxt == PH_KW_MATCH) begin
        done = 1'b1;
        if (nl) begin
          if (tok_idx_nxt != XREF_LEN) begin
            do_fail   = 1'b1;
            fail_kind = KIND_NO_KEYWORD;
          end else begin
            clr_line  = 1'b1;
            phase_nxt = PH_SEEK;
          end
        end else if (tok_idx_nxt < XREF_LEN && c == xref_char(tok_idx_nxt[1:0])) begin
          tok_idx_nxt = tok_idx_nxt + 3'd1;
        end else begin
          kw_ok_nxt = (tok_idx_nxt == XREF_LEN) && tok_end;
          phase_nxt = PH_KW_REST;
        end
      end

      if (!done && phase_nxt == PH_KW_REST) begin
        done = 1'b1;
        if (nl) begin
          if (!kw_ok_nxt) begin
            do_fail   = 1'b1;
            fail_kind = KIND_NO_KEYWORD;
          end else begin
            clr_line  = 1'b1;
            phase_nxt = PH_SEEK;
          end
        end
      end

      // line state is already clear whenever the phase is SEEK
      if (!done && phase_nxt == PH_SEEK) begin
        if (blank) begin
          done = 1'b1;
        end else begin
          phase_nxt = PH_HDR_TRL;
        end
      end

      if (!done && phase_nxt == PH_HDR_TRL) begin
        if (tok_idx_nxt == TRAILER_LEN) begin
          if (tok_end) begin
            done      = 1'b1;
            do_fail   = 1'b1;
            fail_kind = KIND_TABLE_END;
          end else begin
            phase_nxt = PH_HDR;
          end
        end else if (c == trailer_char(tok_idx_nxt)) begin
          tok_idx_nxt = tok_idx_nxt + 3'd1;
        end else begin
          phase_nxt = PH_HDR;
        end
      end

      if (!done && (phase_nxt == PH_HDR_TRL || phase_nxt == PH_HDR)) begin
        done = 1'b1;
        if (nl) begin
          if (!hdr_nxt.split) begin
            do_fail   = 1'b1;
            fail_kind = KIND_NO_SPACE;
          end else if (!hdr_nxt.s_dig || hdr_nxt.s_bad || !hdr_nxt.c_dig || hdr_nxt.c_bad) begin
            do_fail   = 1'b1;
            fail_kind = KIND_BAD_RANGE;
          end else begin
            remain_nxt   = count_nxt[W-1:0];
            next_obj_nxt = start_nxt[W-1:0];
            clr_line     = 1'b1;
            phase_nxt    = (count_nxt[W-1:0] != '0) ? PH_ENTRY : PH_SEEK;
          end
        end else if (blank) begin
          if (!run_nxt.space) begin
            if (c == CH_SPACE) run_nxt.space = 1'b1;
            else               run_nxt.pre   = 1'b1;
          end else begin
            run_nxt.post = 1'b1;
          end
        end else begin
          // a blank run closes: first single-space run splits start from count
          if (run_nxt != '0) begin
            if (hdr_nxt.split) begin
              hdr_nxt.c_bad = 1'b1;
            end else begin
              if (run_nxt.pre)   hdr_nxt.s_bad = 1'b1;
              if (run_nxt.space) hdr_nxt.split = 1'b1;
              if (run_nxt.post)  hdr_nxt.c_bad = 1'b1;
            end
            run_nxt = '0;
          end
          acc      = hdr_nxt.split ? count_nxt : start_nxt;
          acc_prod = (PW'(acc) << 3) + (PW'(acc) << 1) + PW'(digit);
          if (!dig) begin
            if (hdr_nxt.split) hdr_nxt.c_bad = 1'b1;
            else               hdr_nxt.s_bad = 1'b1;
          end else begin
            if (acc_prod[PW-1:W] != '0) begin
              acc = ACC_SAT;
              if (hdr_nxt.split) hdr_nxt.c_bad = 1'b1;
              else               hdr_nxt.s_bad = 1'b1;
            end else begin
              acc = acc_prod[W:0];
            end
            if (hdr_nxt.split) begin
              count_nxt     = acc;
              hdr_nxt.c_dig = 1'b1;
            end else begin
              start_nxt     = acc;
              hdr_nxt.s_dig = 1'b1;
            end
          end
        end
      end

      if (!done && phase_nxt == PH_ENTRY) begin
        done = 1'b1;
        if (nl) begin
          if (trim_nxt < ENTRY_LEN) begin
            do_fail   = 1'b1;
            fail_kind = KIND_SHORT;
          end else if (!fld_nxt.off_ok) begin
            do_fail   = 1'b1;
            fail_kind = KIND_BAD_OFFSET;
          end else if (!fld_nxt.gen_ok || gen_nxt[16]) begin
            do_fail   = 1'b1;
            fail_kind = KIND_BAD_GENERATION;
          end else if (flag_nxt != CH_IN_USE && flag_nxt != CH_FREE) begin
            do_fail   = 1'b1;
            fail_kind = KIND_BAD_FLAG;
          end else begin
            res_valid         = 1'b1;
            res.result_kind   = KIND_ENTRY;
            res.object_number = 32'(next_obj_nxt);
            res.generation    = gen_nxt[15:0];
            res.byte_offset   = off_nxt;
            res.in_use        = (flag_nxt == CH_IN_USE);
            next_obj_nxt      = next_obj_nxt + W'(1);
            remain_nxt        = remain_nxt - W'(1);
            clr_line          = 1'b1;
            if (remain_nxt == '0) phase_nxt = PH_SEEK;
          end
        end else if (blank) begin
          if (col_nxt != '0 && col_nxt < COL_MAX) col_nxt = col_nxt + 5'd1;
        end else begin
          // interior blanks between the last glyph and this one act as spaces
          gap_end = (col_nxt < ENTRY_LEN) ? col_nxt : ENTRY_LEN;
          if (trim_nxt < gap_end) begin
            if (trim_nxt < OFF_COLS) fld_nxt.off_stop = 1'b1;
            if (trim_nxt < GEN_END && gap_end > GEN_FIRST) fld_nxt.gen_stop = 1'b1;
            if (gap_end == ENTRY_LEN) flag_nxt = CH_SPACE;
          end
          if (col_nxt < OFF_COLS) begin
            if (!fld_nxt.off_stop) begin
              if (!dig) begin
                fld_nxt.off_stop = 1'b1;
              end else begin
                off_nxt = (off_nxt << 3) + (off_nxt << 1) + 34'(digit);
                if (col_nxt == '0) fld_nxt.off_ok = 1'b1;
              end
            end
          end else if (col_nxt >= GEN_FIRST && col_nxt < GEN_END) begin
            if (!fld_nxt.gen_stop) begin
              if (!dig) begin
                fld_nxt.gen_stop = 1'b1;
              end else begin
                gen_nxt = (gen_nxt << 3) + (gen_nxt << 1) + 17'(digit);
                if (col_nxt == GEN_FIRST) fld_nxt.gen_ok = 1'b1;
              end
            end
          end else if (col_nxt == FLAG_COL) begin
            flag_nxt = c;
          end
          if (col_nxt < COL_MAX) col_nxt = col_nxt + 5'd1;
          trim_nxt = col_nxt;
        end
      end

      if (clr_line) begin
        col_nxt     = '0;
        trim_nxt    = '0;
        tok_idx_nxt = '0;
        run_nxt     = '0;
        kw_ok_nxt   = 1'b0;
        start_nxt   = '0;
        count_nxt   = '0;
        hdr_nxt     = '0;
        off_nxt     = '0;
        gen_nxt     = '0;
        fld_nxt     = '0;
        flag_nxt    = '0;
      end

      // every non-entry result is final until the next new_table
      if (do_fail) begin
        stopped_nxt     = 1'b1;
        res_valid       = 1'b1;
        res.result_kind = fail_kind;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_KW_LEAD;
      col_r      <= '0;
      trim_r     <= '0;
      tok_idx_r  <= '0;
      run_r      <= '0;
      kw_ok_r    <= 1'b0;
      start_r    <= '0;
      count_r    <= '0;
      hdr_r      <= '0;
      off_r      <= '0;
      gen_r      <= '0;
      fld_r      <= '0;
      flag_r     <= '0;
      remain_r   <= '0;
      next_obj_r <= '0;
      stopped_r  <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      col_r      <= col_nxt;
      trim_r     <= trim_nxt;
      tok_idx_r  <= tok_idx_nxt;
      run_r      <= run_nxt;
      kw_ok_r    <= kw_ok_nxt;
      start_r    <= start_nxt;
      count_r    <= count_nxt;
      hdr_r      <= hdr_nxt;
      off_r      <= off_nxt;
      gen_r      <= gen_nxt;
      fld_r      <= fld_nxt;
      flag_r     <= flag_nxt;
      remain_r   <= remain_nxt;
      next_obj_r <= next_obj_nxt;
      stopped_r  <= stopped_nxt;
    end
  end

  `PXREF_ASSERT_NEXT(a_error_stops, step_en && res_valid && (res.result_kind != KIND_ENTRY), stopped_r)
  `PXREF_ASSERT_NOW(a_quiet_when_stopped, step_en && stopped_r && !item.new_table, !res_valid)
  `PXREF_ASSERT_NEXT(a_entry_advances, step_en && res_valid && (res.result_kind == KIND_ENTRY), next_obj_r == $past(next_obj_r) + W'(1))

endmodule

`default_nettype wire

>>> rtl/core/pdf_xref_table_parser_core.sv
// Cross-reference table parser, one byte per transaction.
// Throughput: one input transaction per cycle, sustained, with an unstalled output.
// The input register holds the accepted byte until it steps the parser, and its result
// is registered in the result register; the input register and the result register
// each hold one transaction. Synchronous active-low reset clears handshake and parser
// state; the parser restarts at the keyword line.
`default_nettype none
`include "pdf_xref_table_parser_core_assert.svh"

module pdf_xref_table_parser_core import pxref_pkg::*; #(
  parameter int OBJECT_NUMBER_WIDTH = 32
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  pxref_stream_if.sink    in_if,
  pxref_stream_if.source  out_if
);

  logic       in_valid_r;
  pxref_in_t  in_r;
  logic       out_valid_r;
  pxref_out_t out_r;
  logic       out_free;
  logic       step_en;
  logic       res_valid;
  pxref_out_t res;

  assign out_free    = !out_valid_r || out_if.ready;
  assign step_en     = in_valid_r && out_free;
  assign in_if.ready = !in_valid_r || step_en;

  assign out_if.valid = out_valid_r;
  assign out_if.data  = out_r;

  pxref_parse #(
    .OBJECT_NUMBER_WIDTH (OBJECT_NUMBER_WIDTH)
  ) u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (step_en),
    .item      (in_r),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        in_valid_r <= 1'b1;
      end else if (step_en) begin
        in_valid_r <= 1'b0;
      end
      if (step_en && res_valid) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) in_r <= in_if.data;
    if (step_en && res_valid) out_r <= res;
  end

  `PXREF_ASSERT_NEXT(a_result_lands, step_en && res_valid, out_valid_r)
  `PXREF_ASSERT_NEXT(a_byte_held, in_valid_r && !out_free, in_valid_r && $stable(in_r))
  `PXREF_ASSERT_NEXT(a_no_phantom, !in_valid_r && !out_valid_r, !out_valid_r)

endmodule

`default_nettype wire

>>> bench/testbench.sv
`timescale 1ns / 100ps

module testbench import pxref_pkg::*;;

  localparam byte unsigned LF = 8'h0a;
  localparam byte unsigned CR = 8'h0d;
  localparam int unsigned LINE_MIN = 18;
  localparam int unsigned COL_SAT = 31;
  localparam logic [63:0] OBJ_LIMIT = 64'hFFFF_FFFF;
  localparam int unsigned ITEMS_PER_MIX = 290;

  // blank-run facts while scanning a header line
  localparam logic [3:0] RUN_SPACE = 4'd1;
  localparam logic [3:0] RUN_PRE = 4'd2;
  localparam logic [3:0] RUN_POST = 4'd4;
  // header verdict bits
  localparam logic [4:0] HF_SPLIT = 5'd1;
  localparam logic [4:0] HF_S_DIG = 5'd2;
  localparam logic [4:0] HF_S_BAD = 5'd4;
  localparam logic [4:0] HF_C_DIG = 5'd8;
  localparam logic [4:0] HF_C_BAD = 5'd16;
  // entry field bits
  localparam logic [4:0] FF_OFF_STOP = 5'd1;
  localparam logic [4:0] FF_OFF_OK = 5'd2;
  localparam logic [4:0] FF_GEN_STOP = 5'd4;
  localparam logic [4:0] FF_GEN_OK = 5'd8;

  typedef enum logic [2:0] {
    PH_KW_LEAD, PH_KW_MATCH, PH_KW_REST, PH_SEEK, PH_HDR_TRL, PH_HDR, PH_ENTRY
  } parse_phase_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic       in_valid = 1'b0;
  pxref_in_t  in_data = '0;
  logic       out_ready = 1'b0;

  pxref_stream_if #(.T(pxref_in_t))  in_ch ();
  pxref_stream_if #(.T(pxref_out_t)) out_ch ();

  assign in_ch.valid = in_valid;
  assign in_ch.data = in_data;
  assign out_ch.ready = out_ready;

  pdf_xref_table_parser_core u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // parser shadow state
  parse_phase_t ph;
  logic [4:0]  col, tlen;
  logic [2:0]  tok_idx;
  logic [3:0]  tok_flags;
  logic [32:0] start_v, count_v;
  logic [4:0]  hdr_f;
  logic [33:0] off_v;
  logic [16:0] gen_v;
  logic [4:0]  fld_f;
  logic [7:0]  flag_ch;
  logic [31:0] remaining, next_obj;
  bit          halted;
  string       kw_xref = "xref";
  string       kw_trailer = "trailer";

  pxref_in_t  byte_q[$];
  pxref_out_t result_q[$];
  pxref_out_t pred_res;
  pxref_out_t want;
  byte unsigned line_buf[$];

  int unsigned in_idle_pct = 9;
  int unsigned out_idle_pct = 66;
  int unsigned queued, tables, accepted, checked, entries_seen, mismatches;
  bit fresh;

  function automatic bit ws_char(logic [7:0] c);
    case (c)
      8'h20, 8'h09, 8'h0a, 8'h0b, 8'h0c, 8'h0d: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit delim_char(logic [7:0] c);
    if (ws_char(c)) return 1'b1;
    case (c)
      "(", ")", "<", ">", "[", "]", "{", "}", "/", "%": return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic void clear_line();
    col = '0; tlen = '0; tok_idx = '0; tok_flags = '0;
    hdr_f = '0; start_v = '0; count_v = '0;
    off_v = '0; gen_v = '0; fld_f = '0; flag_ch = '0;
  endfunction

  function automatic void clear_all();
    clear_line();
    ph = PH_KW_LEAD;
    remaining = '0; next_obj = '0; halted = 1'b0;
  endfunction

  function automatic pxref_out_t halt_with(pxref_kind_t k);
    pxref_out_t r;
    r = '0;
    r.result_kind = k;
    halted = 1'b1;
    return r;
  endfunction

  function automatic void hdr_digit(logic [7:0] c);
    logic [63:0] acc;
    bit second;
    second = (hdr_f & HF_SPLIT) != 0;
    if (!(c >= "0" && c <= "9")) begin
      hdr_f |= second ? HF_C_BAD : HF_S_BAD;
      return;
    end
    acc = (second ? count_v : start_v) * 64'd10 + (c - "0");
    if (acc > OBJ_LIMIT) begin
      acc = OBJ_LIMIT + 64'd1;
      hdr_f |= second ? HF_C_BAD : HF_S_BAD;
    end
    if (second) count_v = acc[32:0];
    else start_v = acc[32:0];
    hdr_f |= second ? HF_C_DIG : HF_S_DIG;
  endfunction

  function automatic void hdr_byte(logic [7:0] c);
    if (ws_char(c)) begin
      if ((tok_flags & RUN_SPACE) == 0) tok_flags |= (c == " ") ? RUN_SPACE : RUN_PRE;
      else tok_flags |= RUN_POST;
      return;
    end
    // a blank run just ended: only a lone space may split start from count
    if (tok_flags != 0) begin
      if (hdr_f & HF_SPLIT) begin
        hdr_f |= HF_C_BAD;
      end else begin
        if (tok_flags & RUN_PRE) hdr_f |= HF_S_BAD;
        if (tok_flags & RUN_SPACE) hdr_f |= HF_SPLIT;
        if (tok_flags & RUN_POST) hdr_f |= HF_C_BAD;
      end
      tok_flags = '0;
    end
    hdr_digit(c);
  endfunction

  function automatic bit header_end(output pxref_out_t r);
    r = '0;
    if (!(hdr_f & HF_SPLIT)) begin
      r = halt_with(KIND_NO_SPACE);
      return 1'b1;
    end
    if (!(hdr_f & HF_S_DIG) || (hdr_f & HF_S_BAD) || !(hdr_f & HF_C_DIG) ||
        (hdr_f & HF_C_BAD)) begin
      r = halt_with(KIND_BAD_RANGE);
      return 1'b1;
    end
    remaining = count_v[31:0];
    next_obj = start_v[31:0];
    clear_line();
    ph = (remaining != 0) ? PH_ENTRY : PH_SEEK;
    return 1'b0;
  endfunction

  function automatic void entry_put(int unsigned pos, logic [7:0] c);
    bit dig;
    dig = c >= "0" && c <= "9";
    if (pos < 10) begin
      if (fld_f & FF_OFF_STOP) return;
      if (!dig) begin
        fld_f |= FF_OFF_STOP;
        return;
      end
      off_v = off_v * 34'd10 + (c - "0");
      if (pos == 0) fld_f |= FF_OFF_OK;
    end else if (pos >= 11 && pos <= 15) begin
      if (fld_f & FF_GEN_STOP) return;
      if (!dig) begin
        fld_f |= FF_GEN_STOP;
        return;
      end
      gen_v = gen_v * 17'd10 + (c - "0");
      if (pos == 11) fld_f |= FF_GEN_OK;
    end else if (pos == 17) begin
      flag_ch = c;
    end
  endfunction

  function automatic void entry_byte(logic [7:0] c);
    int unsigned p;
    if (ws_char(c)) begin
      if (col != 0 && col < COL_SAT) col++;
      return;
    end
    // interior blanks count as spaces once a later non-blank shows up
    for (p = tlen; p < col && p < LINE_MIN; p++) entry_put(p, " ");
    if (col < LINE_MIN) entry_put(col, c);
    if (col < COL_SAT) col++;
    tlen = col;
  endfunction

  function automatic bit entry_end(output pxref_out_t r);
    r = '0;
    if (tlen < LINE_MIN) r = halt_with(KIND_SHORT);
    else if (!(fld_f & FF_OFF_OK)) r = halt_with(KIND_BAD_OFFSET);
    else if (!(fld_f & FF_GEN_OK) || gen_v > 17'd65535) r = halt_with(KIND_BAD_GENERATION);
    else if (flag_ch != "n" && flag_ch != "f") r = halt_with(KIND_BAD_FLAG);
    else begin
      r.result_kind = KIND_ENTRY;
      r.object_number = next_obj;
      r.generation = gen_v[15:0];
      r.byte_offset = off_v;
      r.in_use = (flag_ch == "n");
      next_obj++;
      remaining--;
      clear_line();
      if (remaining == 0) ph = PH_SEEK;
    end
    return 1'b1;
  endfunction

  function automatic bit predict_byte(input pxref_in_t it, output pxref_out_t r);
    logic [7:0] c;
    bit nl;
    c = it.byte_value;
    nl = (c == LF);
    r = '0;
    if (it.new_table) clear_all();
    if (halted) return 1'b0;

    if (it.end_of_data) begin
      if (ph <= PH_KW_REST) r = halt_with(KIND_EOF_KEYWORD);
      else if (ph == PH_SEEK || (ph == PH_HDR_TRL && tok_idx == 3'd7))
        r = halt_with(KIND_TABLE_END);
      else if (ph == PH_ENTRY) r = halt_with(KIND_EOF_ENTRIES);
      else r = halt_with(KIND_EOF_HEADER);
      return 1'b1;
    end

    if (ph == PH_KW_LEAD) begin
      if (nl) begin
        r = halt_with(KIND_NO_KEYWORD);
        return 1'b1;
      end
      if (ws_char(c)) return 1'b0;
      ph = PH_KW_MATCH;
    end
    if (ph == PH_KW_MATCH) begin
      if (nl) begin
        if (tok_idx != 3'd4) begin
          r = halt_with(KIND_NO_KEYWORD);
          return 1'b1;
        end
        clear_line();
        ph = PH_SEEK;
        return 1'b0;
      end
      if (tok_idx < 3'd4) begin
        if (c == kw_xref[tok_idx]) begin
          tok_idx++;
          return 1'b0;
        end
        tok_flags = '0;
      end else begin
        tok_flags = delim_char(c) ? 4'd1 : 4'd0;
      end
      ph = PH_KW_REST;
      return 1'b0;
    end
    if (ph == PH_KW_REST) begin
      if (!nl) return 1'b0;
      if (tok_flags[0] == 1'b0) begin
        r = halt_with(KIND_NO_KEYWORD);
        return 1'b1;
      end
      clear_line();
      ph = PH_SEEK;
      return 1'b0;
    end
    if (ph == PH_SEEK) begin
      if (ws_char(c)) return 1'b0;
      clear_line();
      ph = PH_HDR_TRL;
    end
    // header line that may still turn out to be the trailer keyword
    if (ph == PH_HDR_TRL) begin
      if (tok_idx >= 3'd7) begin
        if (delim_char(c)) begin
          r = halt_with(KIND_TABLE_END);
          return 1'b1;
        end
        ph = PH_HDR;
      end else if (c == kw_trailer[tok_idx]) begin
        tok_idx++;
      end else begin
        ph = PH_HDR;
      end
    end
    if (ph == PH_HDR_TRL || ph == PH_HDR) begin
      if (nl) return header_end(r);
      hdr_byte(c);
      return 1'b0;
    end
    if (ph == PH_ENTRY) begin
      if (nl) return entry_end(r);
      entry_byte(c);
    end
    return 1'b0;
  endfunction

  // stimulus helpers
  task automatic push_byte(byte unsigned b);
    pxref_in_t it;
    it.byte_value = b;
    it.end_of_data = 1'b0;
    it.new_table = fresh;
    fresh = 1'b0;
    byte_q.push_back(it);
    queued++;
  endtask

  task automatic push_eod();
    pxref_in_t it;
    it.byte_value = 8'($urandom_range(255));
    it.end_of_data = 1'b1;
    it.new_table = fresh;
    fresh = 1'b0;
    byte_q.push_back(it);
    queued++;
  endtask

  task automatic push_str(string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  task automatic begin_table();
    fresh = 1'b1;
    tables++;
  endtask

  task automatic buf_text(string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endtask

  task automatic flush_line();
    foreach (line_buf[i]) push_byte(line_buf[i]);
    push_byte(LF);
    line_buf.delete();
  endtask

  function automatic string dec_str(longint unsigned v, int unsigned w);
    string s;
    s = $sformatf("%0d", v);
    while (s.len() < w) s = {"0", s};
    return s;
  endfunction

  function automatic string pad_sp(string s, int unsigned w);
    string t;
    t = s;
    while (t.len() < w) t = {t, " "};
    return t;
  endfunction

  // any byte but a newline
  function automatic byte unsigned text_byte();
    byte unsigned b;
    b = 8'($urandom_range(255));
    if (b == LF) b = 8'h0b;
    return b;
  endfunction

  task automatic gen_entry();
    longint unsigned off;
    int unsigned gen, mode, cut;
    off = {$urandom, $urandom} % 64'd10000000000;
    gen = ($urandom_range(3) == 0) ? $urandom_range(3) : $urandom_range(65535);
    mode = $urandom_range(99);
    line_buf.delete();
    if ($urandom_range(4) == 0) begin
      line_buf.push_back(" ");
      if ($urandom_range(1)) line_buf.push_back(8'h09);
    end
    if (mode < 10) buf_text(pad_sp(dec_str(off % 1000, 1), 10));
    else buf_text(dec_str(off, 10));
    line_buf.push_back($urandom_range(7) == 0 ? text_byte() : 8'h20);
    if (mode >= 10 && mode < 15) gen = $urandom_range(65536, 99999);
    if (mode >= 15 && mode < 22) buf_text(pad_sp(dec_str(gen % 100, 1), 5));
    else buf_text(dec_str(gen, 5));
    line_buf.push_back($urandom_range(7) == 0 ? text_byte() : 8'h20);
    if (mode >= 22 && mode < 27) line_buf.push_back(text_byte());
    else line_buf.push_back($urandom_range(1) ? "n" : "f");
    if ($urandom_range(4) == 0) repeat ($urandom_range(1, 15)) line_buf.push_back(text_byte());
    case ($urandom_range(4))
      1: line_buf.push_back(" ");
      2: line_buf.push_back(CR);
      3: begin
        line_buf.push_back(" ");
        line_buf.push_back(CR);
      end
      4: buf_text("\t ");
      default: ;
    endcase
    if (mode >= 27 && mode < 35) line_buf[$urandom_range(line_buf.size() - 1)] = text_byte();
    if (mode >= 35 && mode < 40) begin
      cut = $urandom_range(line_buf.size() - 1);
      while (line_buf.size() > cut) void'(line_buf.pop_back());
    end
    flush_line();
  endtask

  task automatic gen_header(output longint unsigned cnt);
    longint unsigned sv;
    int unsigned m;
    repeat ($urandom_range(3) == 0 ? $urandom_range(1, 2) : 0)
      push_str($urandom_range(1) ? "\n" : " \t\015\n");
    m = $urandom_range(99);
    if (m < 70) sv = $urandom_range(2000);
    else if (m < 85) sv = 64'hFFFF_FFFF - $urandom_range(3);
    else if (m < 90) sv = 64'h1_0000_0000 + $urandom_range(5);
    else sv = {$urandom, $urandom};
    m = $urandom_range(99);
    if (m < 93) cnt = $urandom_range(4);
    else if (m < 97) cnt = 64'h1_0000_0000 + $urandom_range(9);
    else cnt = 64'hFFFF_FFFF;
    line_buf.delete();
    buf_text(dec_str(sv, $urandom_range(1, 12)));
    case ($urandom_range(19))
      0, 1: buf_text("  ");
      2: buf_text(" \t");
      3: buf_text("\t");
      4: ;
      5: buf_text(" +");
      default: buf_text(" ");
    endcase
    buf_text(dec_str(cnt, $urandom_range(1, 3)));
    case ($urandom_range(5))
      0: buf_text(" ");
      1: line_buf.push_back(CR);
      2: buf_text(" \t");
      default: ;
    endcase
    flush_line();
  endtask

  task automatic gen_table();
    longint unsigned n;
    int unsigned m;
    begin_table();
    m = $urandom_range(99);
    if (m < 80) push_str("xref\n");
    else if (m < 88) push_str(" \t xref \015\n");
    else if (m < 92) push_str("xref%x\n");
    else if (m < 95) push_str("xref[ a\n");
    else if (m < 97) push_str("xrefs\n");
    else push_str("xre\n");
    repeat ($urandom_range(1, 3)) begin
      gen_header(n);
      repeat (n > 4 ? 3 : n) gen_entry();
    end
    m = $urandom_range(99);
    if (m < 30) push_str("trailer\n");
    else if (m < 40) push_str("trailer<</Size 5>>\n");
    else if (m < 48) begin
      push_str(" trailer");
      push_eod();
    end else if (m < 52) push_str("trailerx 1\n");
    else if (m < 75) push_eod();
    else if (m < 85) begin
      push_str("00000");
      push_eod();
    end
    // else the next table's first byte cuts this one off
  endtask

  task automatic gen_noise();
    begin_table();
    if ($urandom_range(1)) push_str("xref\n");
    repeat ($urandom_range(1, 12)) begin
      case ($urandom_range(9))
        0: push_eod();
        1: begin
          fresh = 1'b1;
          push_byte(text_byte());
        end
        default: push_byte(8'($urandom_range(255)));
      endcase
    end
  endtask

  function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  // driver: prediction runs on the byte at the edge where it is accepted
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ch.ready) begin
        accepted++;
        if (predict_byte(in_data, pred_res)) result_q.push_back(pred_res);
      end
      if (!in_valid || in_ch.ready) begin
        if (byte_q.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
          in_valid <= 1'b1;
          in_data <= byte_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ready) begin
        if (result_q.size() == 0) begin
          $error("result transaction with nothing pending: kind %0d",
                 out_ch.data.result_kind);
          mismatches++;
        end else begin
          want = result_q.pop_front();
          checked++;
          if (want.result_kind == KIND_ENTRY) entries_seen++;
          check_field("result_kind", want.result_kind, out_ch.data.result_kind);
          check_field("object_number", want.object_number, out_ch.data.object_number);
          check_field("generation", want.generation, out_ch.data.generation);
          check_field("byte_offset", want.byte_offset, out_ch.data.byte_offset);
          check_field("in_use", want.in_use, out_ch.data.in_use);
        end
      end
      out_ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int unsigned goal;
    clear_all();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extreme field values, every result kind, wraparound
    begin_table();
    push_str("xref\n0 3\n0000000000 65535 f\015\n9999999999 00000 n \n");
    push_str("  0000012345 00007 n and some long trailing text\n");
    push_str("trailer\n");
    begin_table(); push_str("xref"); push_eod(); push_str("zz");
    begin_table(); push_eod();
    begin_table(); push_str("xrefs\n");
    begin_table(); push_str("\n");
    begin_table(); push_str("xref\n1 1\n"); push_eod();
    begin_table(); push_str("xref\n12"); push_eod();
    begin_table(); push_str("xref\n12\n");
    begin_table(); push_str("xref\n4294967296 1\n");
    begin_table(); push_str("xref\n0 1\n0000000001 00000\n");
    begin_table(); push_str("xref\n0 1\nx000000000 00000 n\n");
    begin_table(); push_str("xref\n0 1\n0000000000 65536 n\n");
    begin_table(); push_str("xref\n0 1\n0000000000 00000 q\n");
    begin_table();
    push_str("xref\n4294967295 2\n0000000100 00001 n\n0000000200 00002 f\n");
    push_eod();
    begin_table(); push_str("xref\n0 0\ntrailer"); push_eod();

    for (int mix = 0; mix < 3; mix++) begin
      case (mix)
        0: begin in_idle_pct = 9; out_idle_pct = 66; end
        1: begin in_idle_pct = 66; out_idle_pct = 9; end
        default: begin in_idle_pct = 0; out_idle_pct = 0; end
      endcase
      goal = queued + ITEMS_PER_MIX;
      while (queued < goal) begin
        if ($urandom_range(9) == 0) gen_noise();
        else gen_table();
      end
      while (byte_q.size() != 0) @(negedge clk);
    end

    while (in_valid) @(negedge clk);
    while (result_q.size() != 0) @(negedge clk);
    repeat (16) @(negedge clk);

    $display("Run covered %0d byte transactions over %0d tables under three idle mixes;",
             accepted, tables);
    $display("%0d results checked, %0d of them entries.", checked, entries_seen);
    if (mismatches == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
